@@ design/aes128_block_encrypt_assert.svh @@
// Assertion macros for the AES-128 encryption block checker.
// Depends on nothing; the including module supplies clk and rst.
`ifndef AES128_BLOCK_ENCRYPT_ASSERT_SVH
`define AES128_BLOCK_ENCRYPT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define AES128_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define AES128_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/aes128_pkg.sv @@
// Shared types and the S-box for the AES-128 encryption block.
// No dependencies.
package aes128_pkg;

  // 128-bit block, byte 0 in bits 127:120
  typedef logic [127:0] block_t;
  typedef logic [31:0]  aes_word_t;

  localparam int unsigned Rounds = 10;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] a);
    return SBOX[a];
  endfunction

  // Byte n of a block (n = 0 is the top byte)
  function automatic logic [7:0] byte_of(input block_t b, input int unsigned n);
    return b[127 - 8*n -: 8];
  endfunction

endpackage

@@ design/aes128_key_step.sv @@
// On-the-fly AES-128 key expansion: derives the next round key from the current one.
// Depends on aes128_pkg.
module aes128_key_step (
  input  aes128_pkg::block_t key,
  input  logic [3:0]         round,
  output aes128_pkg::block_t key_next
);

  // Round constant for the given round; codes past the last round give zero
  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    case (r)
      4'd0:    v = 8'h01;
      4'd1:    v = 8'h02;
      4'd2:    v = 8'h04;
      4'd3:    v = 8'h08;
      4'd4:    v = 8'h10;
      4'd5:    v = 8'h20;
      4'd6:    v = 8'h40;
      4'd7:    v = 8'h80;
      4'd8:    v = 8'h1b;
      4'd9:    v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  aes128_pkg::aes_word_t tw;
  aes128_pkg::aes_word_t w0, w1, w2, w3;

  // RotWord + SubWord on the last word, plus rcon
  assign tw = {aes128_pkg::sbox(key[23:16]) ^ rcon(round),
               aes128_pkg::sbox(key[15:8]),
               aes128_pkg::sbox(key[7:0]),
               aes128_pkg::sbox(key[31:24])};

  // Word chain
  assign w0 = key[127:96] ^ tw;
  assign w1 = key[95:64]  ^ w0;
  assign w2 = key[63:32]  ^ w1;
  assign w3 = key[31:0]   ^ w2;

  assign key_next = {w0, w1, w2, w3};

endmodule

@@ design/aes128_round.sv @@
// One AES round: SubBytes, ShiftRows, optional MixColumns, AddRoundKey.
// Depends on aes128_pkg.
module aes128_round (
  input  aes128_pkg::block_t state_in,
  input  aes128_pkg::block_t round_key,
  input  logic               last,
  output aes128_pkg::block_t state_out
);

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  aes128_pkg::block_t shifted;
  aes128_pkg::block_t mixed;

  // SubBytes and ShiftRows: byte r of column c comes from column c+r
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        shifted[127 - 8*(r + 4*c) -: 8] =
          aes128_pkg::sbox(aes128_pkg::byte_of(state_in, r + 4*((c + r) % 4)));
      end
    end
  end

  // MixColumns, one column at a time
  always_comb begin
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0  = aes128_pkg::byte_of(shifted, 4*c);
      a1  = aes128_pkg::byte_of(shifted, 4*c + 1);
      a2  = aes128_pkg::byte_of(shifted, 4*c + 2);
      a3  = aes128_pkg::byte_of(shifted, 4*c + 3);
      all = a0 ^ a1 ^ a2 ^ a3;
      mixed[127 - 32*c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1),
                                 a1 ^ all ^ xtime(a1 ^ a2),
                                 a2 ^ all ^ xtime(a2 ^ a3),
                                 a3 ^ all ^ xtime(a3 ^ a0)};
    end
  end

  // Final round skips MixColumns
  assign state_out = (last ? shifted : mixed) ^ round_key;

endmodule

@@ design/aes128_block_encrypt.sv @@
// Top level of the iterative AES-128 encryption block.
// Depends on aes128_pkg, aes128_key_step and aes128_round.

// Encrypts one 128-bit block with a 128-bit key per command. A word is taken
// at the clock edge where start is high and busy is low; the initial key
// addition happens on that edge. The shared round unit then runs one round per
// cycle up to the last, with the next round key derived alongside it. done
// rises once the last round is registered and the sequencer enters ST_DONE,
// and stays high for one cycle with cipher_hi/cipher_lo valid; the result
// is taken at the edge that ends ST_DONE. busy is low in ST_DONE, so
// a new word may be issued then but not during the rounds. The result is
// shown for that single cycle only and cannot be held off by the receiver.
module aes128_block_encrypt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] key_hi,
  input  logic [63:0] key_lo,
  input  logic [63:0] plain_hi,
  input  logic [63:0] plain_lo,
  output logic        done,
  output logic [63:0] cipher_hi,
  output logic [63:0] cipher_lo
);

  localparam logic [3:0] LastRound = 4'(aes128_pkg::Rounds - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t             state, state_next;
  aes128_pkg::block_t work_block;
  aes128_pkg::block_t round_key;
  logic [3:0]         round_index;
  aes128_pkg::block_t key_next;
  aes128_pkg::block_t block_next;
  logic               accept;

  assign accept = start && !busy;

  // Round key for the round in progress
  aes128_key_step u_key (
    .key      (round_key),
    .round    (round_index),
    .key_next (key_next)
  );

  // Shared round unit
  aes128_round u_round (
    .state_in  (work_block),
    .round_key (key_next),
    .last      (round_index == LastRound),
    .state_out (block_next)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_RUN;
      ST_RUN:  if (round_index == LastRound) state_next = ST_DONE;
      ST_DONE: state_next = accept ? ST_RUN : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      round_index <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        round_index <= '0;
      end else if (state == ST_RUN) begin
        round_index <= round_index + 4'd1;
      end
    end
  end

  // Datapath: load with initial key addition, then one round per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      work_block <= '0;
      round_key  <= '0;
    end else if (accept) begin
      work_block <= {plain_hi, plain_lo} ^ {key_hi, key_lo};
      round_key  <= {key_hi, key_lo};
    end else if (state == ST_RUN) begin
      work_block <= block_next;
      round_key  <= key_next;
    end
  end

  assign busy      = (state == ST_RUN);
  assign done      = (state == ST_DONE);
  assign cipher_hi = work_block[127:64];
  assign cipher_lo = work_block[63:0];

endmodule

@@ design/aes128_checker.sv @@
// Port-level checker for the AES-128 encryption block, bound to the top level.
// Depends on aes128_block_encrypt_assert.svh and aes128_block_encrypt.
`include "aes128_block_encrypt_assert.svh"

module aes128_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // A command keeps the block busy from the next cycle
  `AES128_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after command")

  // Fixed latency from command to result strobe
  `AES128_ASSERT_IMPL(a_latency, start && !busy, ##11 done, "result not after 11 cycles")

  // Result strobe only while not busy, and for one cycle
  `AES128_ASSERT_IMPL(a_done_idle, done, !busy, "done while busy")
  `AES128_ASSERT_NEXT(a_done_pulse, done, !done, "done held longer than one cycle")

  // A result always follows a busy period
  `AES128_ASSERT_IMPL(a_done_after_busy, done, $past(busy), "done without preceding work")

endmodule

bind aes128_block_encrypt aes128_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
